>>> design/jsrd_pkg.sv
// ----------------------------------------------------------------------------
// jsrd_pkg
// Shared types and constants for the joystick smoothstep ramp drive.
// ----------------------------------------------------------------------------
package jsrd_pkg;

  localparam int SAMPLE_BITS = 10;

  localparam int CENTER_W = 10;
  localparam int DZ_W     = 9;
  localparam int RANGE_W  = 10;
  localparam int STEP_W   = 8;
  localparam int DMAX_W   = 8;
  localparam int CFG_W    = 10;
  localparam int CFG_IDX_W = 3;

  localparam int MAG_W  = (SAMPLE_BITS > CENTER_W) ? SAMPLE_BITS : CENTER_W;
  localparam int SPAN_W = RANGE_W;
  localparam int QUOT_W = 16;
  localparam int CNT_W  = $clog2(QUOT_W);

  localparam int T_W    = QUOT_W + 1;
  localparam int MUL_W  = T_W + 1;
  localparam int PROD_W = 2 * MUL_W;
  localparam int DUTY_W = 16;

  localparam logic [T_W-1:0]   ONE_Q16   = T_W'(65536);
  localparam logic [MUL_W-1:0] THREE_Q16 = MUL_W'(196608);

  localparam logic [CENTER_W-1:0] CENTER_RST = CENTER_W'(512);
  localparam logic [DZ_W-1:0]     DZ_RST     = DZ_W'(40);
  localparam logic [RANGE_W-1:0]  RANGE_RST  = RANGE_W'(470);
  localparam logic [STEP_W-1:0]   STEP_RST   = STEP_W'(8);
  localparam logic [DMAX_W-1:0]   DMAX_RST   = DMAX_W'(200);

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_RANGE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MAX   = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_SQ,
    S_CUBE,
    S_SCALE,
    S_RAMP
  } state_e;

endpackage

>>> design/jsrd_div.sv
// ----------------------------------------------------------------------------
// jsrd_div
// Radix-2 restoring divider, one quotient bit per cycle, fraction only.
// ----------------------------------------------------------------------------
module jsrd_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [jsrd_pkg::SPAN_W-1:0]   dividend_i,
  input  logic [jsrd_pkg::SPAN_W-1:0]   divisor_i,
  output logic                          done_o,
  output logic [jsrd_pkg::QUOT_W-1:0]   quot_o
);
  import jsrd_pkg::*;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [SPAN_W-1:0]   rem_q, rem_d;
  logic [SPAN_W-1:0]   dvs_q, dvs_d;
  logic [QUOT_W-1:0]   quot_q, quot_d;
  logic [SPAN_W:0]     rem2;
  logic                ge;

  always_comb begin
    rem2   = {rem_q, 1'b0};
    ge     = rem2 >= {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = dividend_i;
      dvs_d  = divisor_i;
      quot_d = '0;
    end else if (busy_q) begin
      rem_d  = ge ? SPAN_W'(rem2 - {1'b0, dvs_q}) : SPAN_W'(rem2);
      quot_d = {quot_q[QUOT_W-2:0], ge};
      cnt_d  = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(QUOT_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

>>> design/jsrd_mul.sv
// ----------------------------------------------------------------------------
// jsrd_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module jsrd_mul (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [jsrd_pkg::MUL_W-1:0]    a_i,
  input  logic [jsrd_pkg::MUL_W-1:0]    b_i,
  output logic [jsrd_pkg::PROD_W-1:0]   p_o
);
  import jsrd_pkg::*;

  logic [PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= PROD_W'(a_i) * PROD_W'(b_i);
    end
  end

  assign p_o = p_q;

endmodule

>>> design/joystick_smoothstep_ramp_drive.sv
// ----------------------------------------------------------------------------
// joystick_smoothstep_ramp_drive
// Deadzone, smoothstep shaping and slew-limited duty for an H-bridge drive.
// ----------------------------------------------------------------------------
// Sequence: prepare, then the ramp step directly in stop; when deflection
// saturates, square, cube, scale, ramp; else divide, then square, cube, scale, ramp.
// Items: one at a time; the next item is taken the cycle after the
// result is loaded; the ramp step waits while the output is stalled.
// Reset: config registers return to their defaults, the stored ramp duty clears to zero.
module joystick_smoothstep_ramp_drive (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [jsrd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [jsrd_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [jsrd_pkg::SAMPLE_BITS-1:0]   raw_x_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               line_a_o,
  output logic                               line_b_o,
  output logic [7:0]                         duty_o,
  output logic [7:0]                         target_duty_o
);
  import jsrd_pkg::*;

  state_e state_q, state_d;

  logic [CENTER_W-1:0] center_q;
  logic [DZ_W-1:0]     deadzone_q;
  logic [RANGE_W-1:0]  full_range_q;
  logic [STEP_W-1:0]   ramp_step_q;
  logic [DMAX_W-1:0]   duty_max_q;

  logic [SAMPLE_BITS-1:0] raw_q;
  logic                   fwd_q, fwd_d;
  logic                   stop_q, stop_d;
  logic [T_W-1:0]         t_q, t_d;
  logic [DUTY_W-1:0]      ramp_q, ramp_d;

  logic       out_valid_q, out_valid_d;
  logic       line_a_q, line_b_q;
  logic [7:0] duty_q, target_duty_q;
  logic       load_out;

  logic [MAG_W-1:0]  raw_ext, ctr_ext, mag, excess;
  logic [SPAN_W-1:0] span;
  logic              span_pos, sat, stop_now;

  logic              div_start, div_done;
  logic [QUOT_W-1:0] quot;

  logic              mul_en;
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod;
  logic [T_W-1:0]    t2;
  logic [MUL_W-1:0]  poly;
  logic [PROD_W-17:0] s_full;
  logic [T_W-1:0]    s_sat;

  logic [DUTY_W-1:0] target, step, ramp_nx;
  logic [DUTY_W:0]   up, tgt_plus;
  logic [7:0]        duty_clamp;

  jsrd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (excess[SPAN_W-1:0]),
    .divisor_i  (span),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  jsrd_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  always_comb begin
    raw_ext  = MAG_W'(raw_q);
    ctr_ext  = MAG_W'(center_q);
    mag      = (raw_ext >= ctr_ext) ? (raw_ext - ctr_ext) : (ctr_ext - raw_ext);
    stop_now = mag <= MAG_W'(deadzone_q);
    excess   = mag - MAG_W'(deadzone_q);
    span_pos = full_range_q > RANGE_W'(deadzone_q);
    span     = full_range_q - RANGE_W'(deadzone_q);
    sat      = !span_pos || (excess >= MAG_W'(span));

    t2     = prod[32:16];
    poly   = THREE_Q16 - {t_q, 1'b0};
    s_full = prod[PROD_W-1:16];
    s_sat  = (s_full > (PROD_W-16)'(ONE_Q16)) ? ONE_Q16 : s_full[T_W-1:0];

    target   = stop_q ? '0 : prod[23:8];
    step     = {ramp_step_q, 8'h00};
    up       = {1'b0, ramp_q} + {1'b0, step};
    tgt_plus = {1'b0, target} + {1'b0, step};
    if (ramp_q < target) begin
      ramp_nx = (up < {1'b0, target}) ? up[DUTY_W-1:0] : target;
    end else if (ramp_q > target) begin
      ramp_nx = ({1'b0, ramp_q} >= tgt_plus) ? (ramp_q - step) : target;
    end else begin
      ramp_nx = ramp_q;
    end
    duty_clamp = (ramp_nx[15:8] > duty_max_q) ? duty_max_q : ramp_nx[15:8];
  end

  always_comb begin
    state_d   = state_q;
    fwd_d     = fwd_q;
    stop_d    = stop_q;
    t_d       = t_q;
    ramp_d    = ramp_q;
    div_start = 1'b0;
    load_out  = 1'b0;
    mul_en    = 1'b1;
    mul_a     = '0;
    mul_b     = '0;
    in_stall_o = (state_q != S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        fwd_d  = raw_ext > ctr_ext;
        stop_d = stop_now;
        if (stop_now) begin
          state_d = S_RAMP;
        end else if (sat) begin
          t_d     = ONE_Q16;
          state_d = S_SQ;
        end else begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          t_d     = T_W'(quot);
          state_d = S_SQ;
        end
      end
      S_SQ: begin
        mul_a   = MUL_W'(t_q);
        mul_b   = MUL_W'(t_q);
        state_d = S_CUBE;
      end
      S_CUBE: begin
        mul_a   = MUL_W'(t2);
        mul_b   = poly;
        state_d = S_SCALE;
      end
      S_SCALE: begin
        mul_a   = MUL_W'(s_sat);
        mul_b   = MUL_W'(duty_max_q);
        state_d = S_RAMP;
      end
      S_RAMP: begin
        mul_en = 1'b0;
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          ramp_d   = ramp_nx;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    out_valid_d = load_out || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ramp_q      <= '0;
      out_valid_q <= 1'b0;
      center_q     <= CENTER_RST;
      deadzone_q   <= DZ_RST;
      full_range_q <= RANGE_RST;
      ramp_step_q  <= STEP_RST;
      duty_max_q   <= DMAX_RST;
    end else begin
      state_q     <= state_d;
      ramp_q      <= ramp_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CENTER:     center_q     <= cfg_wdata_i[CENTER_W-1:0];
          CFG_DEADZONE:   deadzone_q   <= cfg_wdata_i[DZ_W-1:0];
          CFG_FULL_RANGE: full_range_q <= cfg_wdata_i[RANGE_W-1:0];
          CFG_RAMP_STEP:  ramp_step_q  <= cfg_wdata_i[STEP_W-1:0];
          CFG_DUTY_MAX:   duty_max_q   <= cfg_wdata_i[DMAX_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      raw_q <= raw_x_i;
    end
    fwd_q  <= fwd_d;
    stop_q <= stop_d;
    t_q    <= t_d;
    if (load_out) begin
      line_a_q      <= !stop_q && fwd_q;
      line_b_q      <= !stop_q && !fwd_q;
      duty_q        <= stop_q ? 8'h00 : duty_clamp;
      target_duty_q <= target[15:8];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign line_a_o      = line_a_q;
  assign line_b_o      = line_b_q;
  assign duty_o        = duty_q;
  assign target_duty_o = target_duty_q;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("item accepted but block not busy");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside divide state");

  a_lines_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(line_a_o && line_b_o))
    else $error("both bridge lines high");

  a_stop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !line_a_o && !line_b_o) |-> (duty_o == 8'h00 && target_duty_o == 8'h00))
    else $error("nonzero duty in stop");
`endif

endmodule
